// ===== hw/rtl/vfcm_pkg.sv =====
// ----------------------------------------------------------------------------
// vfcm_pkg
// Shared widths, request codes, sequencer states and face tables for the
// culled-face voxel mesher.
// ----------------------------------------------------------------------------
package vfcm_pkg;

    localparam int POS_W        = 4;
    localparam int TYPE_W       = 8;
    localparam int VERT_W       = 5;
    localparam int NRM_W        = 2;
    localparam int VNUM_W       = 17;
    localparam int S_DATA_W     = 24;
    localparam int M_DATA_W     = 40;
    localparam int NUM_FACES    = 6;
    localparam int SIDE_DEFAULT = 16;

    localparam logic [VNUM_W-1:0] VCOUNT_MAX = 17'd98303;

    typedef enum logic [1:0] {
        REQ_WRITE   = 2'd0,
        REQ_MESH    = 2'd1,
        REQ_RESTART = 2'd2
    } req_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_EMIT
    } state_t;

    // Corner offsets of one face, corner c in bits [3c+2:3c] as {x, y, z}.
    function automatic logic [11:0] face_corners(input logic [2:0] face);
        logic [11:0] res;
        unique case (face)
            3'd0:    res = {3'b101, 3'b111, 3'b110, 3'b100};
            3'd1:    res = {3'b000, 3'b010, 3'b011, 3'b001};
            3'd2:    res = {3'b110, 3'b111, 3'b011, 3'b010};
            3'd3:    res = {3'b101, 3'b100, 3'b000, 3'b001};
            3'd4:    res = {3'b011, 3'b111, 3'b101, 3'b001};
            3'd5:    res = {3'b110, 3'b010, 3'b000, 3'b100};
            default: res = '0;
        endcase
        return res;
    endfunction

endpackage

// ===== hw/rtl/vfcm_map.sv =====
// ----------------------------------------------------------------------------
// vfcm_map
// Solid-bit map: one-bit synchronous memory with registered read data and a
// clearing pass after reset that zeroes every entry, one per cycle.
// ----------------------------------------------------------------------------
module vfcm_map
    import vfcm_pkg::*;
#(
    parameter int AW = 12
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic          wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic          rd_data,
    output logic          map_ready
);

    logic          mem [2**AW];
    logic          clr_busy_reg, clr_busy_next;
    logic [AW-1:0] clr_addr_reg, clr_addr_next;
    logic          rd_data_reg;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic          mem_wdata;

    always_comb begin
        clr_busy_next = clr_busy_reg;
        clr_addr_next = clr_addr_reg;
        if (clr_busy_reg) begin
            clr_addr_next = clr_addr_reg + AW'(1);
            if (clr_addr_reg == '1) begin
                clr_busy_next = 1'b0;
            end
        end
        mem_we    = clr_busy_reg | wr_en;
        mem_waddr = clr_busy_reg ? clr_addr_reg : wr_addr;
        mem_wdata = clr_busy_reg ? 1'b0 : wr_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else begin
            clr_busy_reg <= clr_busy_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data   = rd_data_reg;
    assign map_ready = ~clr_busy_reg;

endmodule

// ===== hw/rtl/voxel_face_culling_mesher.sv =====
// ----------------------------------------------------------------------------
// voxel_face_culling_mesher
// Culled-face voxel mesher: stores solid bits of a cubic chunk and emits the
// four vertices of every exposed face of a requested voxel.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the s_ stream, one item per request; s_tuser selects
//   write a voxel, mesh a voxel, or restart vertex numbering. Vertices leave
//   on the m_ stream, one item each; m_tlast marks the final vertex of a mesh
//   request. Write and restart requests give no items.
//   A mesh request probes the map through its one read port: the center and
//   six neighbors are read in turn, then the face mask is registered, then
//   one vertex per cycle follows while the receiver is ready, up to 24. Air
//   and fully hidden voxels and out-of-chunk positions give no items. The next
//   request is taken once the last vertex sits in the output register.
//   After reset the map clears all 2**(3*clog2(SIDE)) entries, one per cycle
//   (4096 entries for SIDE = 16), with s_tready low; the vertex number is zero.
//   A stalled receiver holds the output register and pauses vertex output.
// ----------------------------------------------------------------------------
module voxel_face_culling_mesher
    import vfcm_pkg::*;
#(
    parameter int SIDE = SIDE_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // pos_x[3:0], pos_y[7:4], pos_z[11:8], voxel_type[19:12]
    input  logic [S_DATA_W-1:0] s_tdata,
    // req_type[1:0]
    input  logic [1:0]          s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // vert_x[4:0], vert_y[9:5], vert_z[14:10], normal_x[16:15],
    // normal_y[18:17], normal_z[20:19], tex_u[21], tex_v[22],
    // vertex_number[39:23]
    output logic [M_DATA_W-1:0] m_tdata,
    output logic                m_tlast
);

    localparam int CW = $clog2(SIDE);
    localparam int EW = (CW + 1 > POS_W) ? CW + 1 : POS_W;
    localparam int AW = 3 * CW;

    state_t              state_reg, state_next;
    logic [2:0]          pc_reg, pc_next;
    logic [5:0]          bits_reg, bits_next;
    logic [5:0]          mask_reg, mask_next;
    logic [1:0]          corner_reg, corner_next;
    logic [POS_W-1:0]    x_reg, x_next, y_reg, y_next, z_reg, z_next;
    logic [VNUM_W-1:0]   vcount_reg, vcount_next;
    logic                m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0] m_data_reg, m_data_next;
    logic                m_last_reg, m_last_next;

    logic [1:0]        in_req;
    logic [POS_W-1:0]  in_x, in_y, in_z;
    logic [TYPE_W-1:0] in_type;
    logic [EW-1:0]     in_xe, in_ye, in_ze, x_e, y_e, z_e;
    logic              in_chunk;
    logic [CW-1:0]     xc, yc, zc, nxc, nyc, nzc;
    logic [AW-1:0]     in_addr, rd_addr;
    logic              rd_data, map_ready;
    logic              map_we;
    logic [5:0]        edge_vec;
    logic [6:0]        probe_all;
    logic [5:0]        mask_new, mask_clr;
    logic [2:0]        probe_face, cur_face;
    logic [11:0]       corners;
    logic [2:0]        off;
    logic [NRM_W-1:0]  nrm_val;
    logic              s_accept, out_free;

    assign in_req  = s_tuser;
    assign in_x    = s_tdata[3:0];
    assign in_y    = s_tdata[7:4];
    assign in_z    = s_tdata[11:8];
    assign in_type = s_tdata[19:12];

    assign in_xe    = EW'(in_x);
    assign in_ye    = EW'(in_y);
    assign in_ze    = EW'(in_z);
    assign in_chunk = (in_xe < EW'(SIDE)) && (in_ye < EW'(SIDE)) && (in_ze < EW'(SIDE));
    assign in_addr  = {in_ze[CW-1:0], in_ye[CW-1:0], in_xe[CW-1:0]};

    assign x_e = EW'(x_reg);
    assign y_e = EW'(y_reg);
    assign z_e = EW'(z_reg);
    assign xc  = x_e[CW-1:0];
    assign yc  = y_e[CW-1:0];
    assign zc  = z_e[CW-1:0];

    assign edge_vec = {zc == '0, zc == CW'(SIDE - 1),
                       yc == '0, yc == CW'(SIDE - 1),
                       xc == '0, xc == CW'(SIDE - 1)};

    assign probe_face = pc_reg - 3'd1;

    always_comb begin
        nxc = xc;
        nyc = yc;
        nzc = zc;
        case (probe_face)
            3'd0:    nxc = xc + CW'(1);
            3'd1:    nxc = xc - CW'(1);
            3'd2:    nyc = yc + CW'(1);
            3'd3:    nyc = yc - CW'(1);
            3'd4:    nzc = zc + CW'(1);
            3'd5:    nzc = zc - CW'(1);
            default: ;
        endcase
        rd_addr = (pc_reg == 3'd0) ? {zc, yc, xc} : {nzc, nyc, nxc};
    end

    assign probe_all = {rd_data, bits_reg};
    assign mask_new  = {6{probe_all[0]}} & (edge_vec | ~probe_all[6:1]);

    always_comb begin
        cur_face = 3'd0;
        for (int i = NUM_FACES - 1; i >= 0; i--) begin
            if (mask_reg[i]) begin
                cur_face = 3'(i);
            end
        end
    end

    assign mask_clr = mask_reg & ~(6'b1 << cur_face);
    assign corners  = face_corners(cur_face);
    assign off      = corners[3 * corner_reg +: 3];
    assign nrm_val  = cur_face[0] ? 2'b11 : 2'b01;

    assign s_tready = (state_reg == ST_IDLE) && map_ready;
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign map_we   = s_accept && (in_req == REQ_WRITE) && in_chunk;

    vfcm_map #(
        .AW (AW)
    ) u_map (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr_en     (map_we),
        .wr_addr   (in_addr),
        .wr_data   (in_type != '0),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .map_ready (map_ready)
    );

    always_comb begin
        state_next   = state_reg;
        pc_next      = pc_reg;
        bits_next    = bits_reg;
        mask_next    = mask_reg;
        corner_next  = corner_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        z_next       = z_reg;
        vcount_next  = vcount_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    if (in_req == REQ_RESTART) begin
                        vcount_next = '0;
                    end else if (in_req == REQ_MESH && in_chunk) begin
                        x_next     = in_x;
                        y_next     = in_y;
                        z_next     = in_z;
                        pc_next    = 3'd0;
                        state_next = ST_PROBE;
                    end
                end
            end
            ST_PROBE: begin
                pc_next = pc_reg + 3'd1;
                if (pc_reg != 3'd0 && pc_reg != 3'd7) begin
                    bits_next[probe_face] = rd_data;
                end
                if (pc_reg == 3'd7) begin
                    mask_next   = mask_new;
                    corner_next = 2'd0;
                    state_next  = (mask_new != '0) ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {vcount_reg,
                                    corner_reg[1],
                                    corner_reg[0] ^ corner_reg[1],
                                    (cur_face[2:1] == 2'd2) ? nrm_val : 2'b00,
                                    (cur_face[2:1] == 2'd1) ? nrm_val : 2'b00,
                                    (cur_face[2:1] == 2'd0) ? nrm_val : 2'b00,
                                    VERT_W'(z_reg) + VERT_W'(off[0]),
                                    VERT_W'(y_reg) + VERT_W'(off[1]),
                                    VERT_W'(x_reg) + VERT_W'(off[2])};
                    m_last_next  = (corner_reg == 2'd3) && (mask_clr == '0);
                    if (vcount_reg < VCOUNT_MAX) begin
                        vcount_next = vcount_reg + VNUM_W'(1);
                    end
                    corner_next = corner_reg + 2'd1;
                    if (corner_reg == 2'd3) begin
                        mask_next = mask_clr;
                        if (mask_clr == '0) begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pc_reg      <= '0;
            mask_reg    <= '0;
            corner_reg  <= '0;
            vcount_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pc_reg      <= pc_next;
            mask_reg    <= mask_next;
            corner_reg  <= corner_next;
            vcount_reg  <= vcount_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        bits_reg   <= bits_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        z_reg      <= z_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    a_vcount_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        vcount_reg <= VCOUNT_MAX)
        else $error("vertex number above saturation limit");

    a_emit_has_face: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_EMIT |-> mask_reg != '0)
        else $error("emitting with empty face mask");

    a_mesh_starts_probe: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && in_req == REQ_MESH && in_chunk |=> state_reg == ST_PROBE && pc_reg == 3'd0)
        else $error("mesh request did not start probing");

    a_clear_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        !map_ready |-> !s_tready)
        else $error("request taken during map clear");

endmodule
